/* rtl/core/bsb_pkg.sv */
package bsb_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_MERGE_PT  = 2'd1,
        OP_MERGE_BND = 2'd2,
        OP_XFORM     = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOX,
        ST_ESQ,
        ST_ESQRT,
        ST_DSQ,
        ST_DSQRT,
        ST_XC,
        ST_XE,
        ST_XS,
        ST_SSQRT,
        ST_RAD,
        ST_FIN
    } t_state;

    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned REG_W    = 64;
    localparam int unsigned IDX_W    = 3;

    localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;
    localparam logic [31:0] MAX_S32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_S32 = 32'h8000_0000;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] t_mat;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] extent_x;
        logic        [30:0] extent_y;
        logic        [30:0] extent_z;
        logic        [30:0] radius;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_center_x;
        logic signed [31:0] out_center_y;
        logic signed [31:0] out_center_z;
        logic        [30:0] out_extent_x;
        logic        [30:0] out_extent_y;
        logic        [30:0] out_extent_z;
        logic        [30:0] out_radius;
    } t_out_item;

    // Pick matrix entry (row, col); col 3 is the translation
    function automatic logic signed [31:0] f_mat(t_mat m, logic [1:0] row, logic [1:0] col);
        logic [2:0] base;
        logic signed [31:0] v;
        base = {row, 1'b0};
        case (col)
            2'd0:    v = m[base][31:0];
            2'd1:    v = m[base][63:32];
            2'd2:    v = m[base + 3'd1][31:0];
            default: v = m[base + 3'd1][63:32];
        endcase
        return v;
    endfunction

    // Magnitude of a signed word as unsigned
    function automatic logic [31:0] f_abs(logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* rtl/core/bsb_in_if.sv */
interface bsb_in_if;
    import bsb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/bsb_out_if.sv */
interface bsb_out_if;
    import bsb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/bsb_isqrt.sv */
module bsb_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);
    import bsb_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_try;

    assign w_try = r_res + r_bit;

    // Control: one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: restoring digit step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= 64'd0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_n >= w_try) begin
                r_n   <= r_n - w_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

/* rtl/core/box_sphere_bounds_merge_transform.sv */
// Channel  | Direction | Handshake       | Payload
// i_in     | in        | valid / ready   | op, center_x/y/z, extent_x/y/z, radius
// o_out    | out       | valid / ready   | out_center_x/y/z, out_extent_x/y/z, out_radius
// i_cfg_*  | in        | write enable    | register index, 64-bit data
//
// One item at a time. A load goes from idle to the final state, where its result is
// registered; a merge runs box, extent square and root, distance square and root; a
// transform runs centre, extent and scale sums, a root and the radius scale. Both are
// sequenced through the shared 33x33 multiplier (one product per cycle, summed in
// three-term groups) and the square root unit that resolves one bit per cycle.
// Reset is synchronous and clears the bound to zero and the matrix to its defaults.
// A held result stalls only the final write; the next item is taken once that write is done.
module box_sphere_bounds_merge_transform (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bsb_in_if.sink                     i_in,
    bsb_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [bsb_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [bsb_pkg::REG_W-1:0]  i_cfg_data
);
    import bsb_pkg::*;

    t_state             r_state, n_state;
    logic [1:0]         r_grp, n_grp;
    logic [2:0]         r_cnt, n_cnt;
    logic signed [31:0] r_c  [3];
    logic signed [31:0] n_c  [3];
    logic [30:0]        r_e  [3];
    logic [30:0]        n_e  [3];
    logic [30:0]        r_r, n_r;
    logic signed [31:0] r_oc [3];
    logic signed [31:0] n_oc [3];
    logic [30:0]        r_oe [3];
    logic [30:0]        n_oe [3];
    logic [30:0]        r_orad, n_orad;
    logic signed [31:0] r_tc [3];
    logic signed [31:0] n_tc [3];
    logic [30:0]        r_te [3];
    logic [30:0]        n_te [3];
    logic signed [65:0] r_prod;
    logic signed [65:0] r_acc, n_acc;
    logic [31:0]        r_elen, n_elen;
    logic [63:0]        r_colmax, n_colmax;
    logic [31:0]        r_scale, n_scale;
    t_mat               r_mat;
    t_out_item          r_out, n_out;
    logic               r_ovld, n_ovld;

    logic [1:0]         w_k;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic signed [32:0] w_d, w_dabs;
    logic [31:0]        w_dcl;
    logic [63:0]        w_cmax;
    logic               w_sq_start;
    logic [63:0]        w_sq_n;
    logic               w_sq_done;
    logic [31:0]        w_sq_root;
    logic signed [65:0] w_xc;
    logic signed [31:0] w_t;
    logic [30:0]        w_rmax;
    logic [32:0]        w_rsum, w_rmin;
    logic signed [33:0] w_lo_a [3];
    logic signed [33:0] w_lo_b [3];
    logic signed [33:0] w_hi_a [3];
    logic signed [33:0] w_hi_b [3];
    logic signed [33:0] w_lo   [3];
    logic signed [33:0] w_hi   [3];
    logic signed [34:0] w_sum  [3];
    logic signed [34:0] w_dif  [3];
    logic signed [31:0] w_bc   [3];
    logic [30:0]        w_be   [3];

    bsb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_n     (w_sq_n),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_out;

    // Box of both corner sets, all three axes side by side
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lo_a[k] = 34'(r_c[k]) - $signed({3'b0, r_e[k]});
            w_hi_a[k] = 34'(r_c[k]) + $signed({3'b0, r_e[k]});
            w_lo_b[k] = 34'(r_oc[k]) - $signed({3'b0, r_oe[k]});
            w_hi_b[k] = 34'(r_oc[k]) + $signed({3'b0, r_oe[k]});
            w_lo[k]   = (w_lo_b[k] < w_lo_a[k]) ? w_lo_b[k] : w_lo_a[k];
            w_hi[k]   = (w_hi_b[k] > w_hi_a[k]) ? w_hi_b[k] : w_hi_a[k];
            w_sum[k]  = (35'(w_lo[k]) + 35'(w_hi[k])) >>> 1;
            w_dif[k]  = (35'(w_hi[k]) - 35'(w_lo[k])) >>> 1;
            if (w_sum[k][34:31] == 4'b0000 || w_sum[k][34:31] == 4'b1111) begin
                w_bc[k] = w_sum[k][31:0];
            end else begin
                w_bc[k] = w_sum[k][34] ? MIN_S32 : MAX_S32;
            end
            w_be[k] = (w_dif[k][34:31] != 4'b0000) ? MAX31 : w_dif[k][30:0];
        end
    end

    // Shared multiplier operand select
    always_comb begin
        w_k    = (r_cnt > 3'd2) ? 2'd2 : r_cnt[1:0];
        w_d    = 33'(r_c[w_k]) - 33'(r_oc[w_k]);
        w_dabs = w_d[32] ? -w_d : w_d;
        w_dcl  = (w_dabs > 33'sh0_8000_0000) ? 32'h8000_0000 : w_dabs[31:0];
        case (r_state)
            ST_ESQ: begin
                w_ma = $signed({2'b0, r_e[w_k]});
                w_mb = $signed({2'b0, r_e[w_k]});
            end
            ST_DSQ: begin
                w_ma = $signed({1'b0, w_dcl});
                w_mb = $signed({1'b0, w_dcl});
            end
            ST_XC: begin
                w_ma = 33'(f_mat(r_mat, r_grp, w_k));
                w_mb = 33'(r_c[w_k]);
            end
            ST_XE: begin
                w_ma = $signed({1'b0, f_abs(f_mat(r_mat, r_grp, w_k))});
                w_mb = $signed({2'b0, r_e[w_k]});
            end
            ST_XS: begin
                w_ma = $signed({1'b0, f_abs(f_mat(r_mat, w_k, r_grp))});
                w_mb = $signed({1'b0, f_abs(f_mat(r_mat, w_k, r_grp))});
            end
            ST_RAD: begin
                w_ma = (r_cnt == 3'd0) ? $signed({2'b0, r_r}) : 33'sd0;
                w_mb = $signed({1'b0, r_scale});
            end
            default: begin
                w_ma = 33'sd0;
                w_mb = 33'sd0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // Next state and datapath updates
    always_comb begin
        n_state    = r_state;
        n_grp      = r_grp;
        n_cnt      = r_cnt;
        n_c        = r_c;
        n_e        = r_e;
        n_r        = r_r;
        n_oc       = r_oc;
        n_oe       = r_oe;
        n_orad     = r_orad;
        n_tc       = r_tc;
        n_te       = r_te;
        n_acc      = r_acc;
        n_elen     = r_elen;
        n_colmax   = r_colmax;
        n_scale    = r_scale;
        n_out      = r_out;
        n_ovld     = r_ovld;
        w_sq_start = 1'b0;

        w_cmax = (r_grp == 2'd0 || r_acc[63:0] > r_colmax) ? r_acc[63:0] : r_colmax;
        w_sq_n = (r_state == ST_XS) ? w_cmax : r_acc[63:0];

        w_t  = f_mat(r_mat, r_grp, 2'd3);
        w_xc = (r_acc >>> 16) + 66'(w_t);

        w_rmax = (r_r > r_orad) ? r_r : r_orad;
        w_rsum = {2'b0, w_rmax} + {1'b0, w_sq_root};
        w_rmin = ({1'b0, r_elen} < w_rsum) ? {1'b0, r_elen} : w_rsum;

        if (o_out.valid && o_out.ready) begin
            n_ovld = 1'b0;
        end

        // Accumulate the previous product inside a three-term group
        if (r_state == ST_ESQ || r_state == ST_DSQ || r_state == ST_XC ||
            r_state == ST_XE || r_state == ST_XS || r_state == ST_RAD) begin
            if (r_cnt == 3'd1) begin
                n_acc = r_prod;
            end else if (r_cnt == 3'd2 || r_cnt == 3'd3) begin
                n_acc = r_acc + r_prod;
            end
            if (r_cnt != 3'd4) begin
                n_cnt = r_cnt + 3'd1;
            end else begin
                n_cnt = 3'd0;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_cnt = 3'd0;
                    n_grp = 2'd0;
                    n_oc[0] = i_in.data.center_x;
                    n_oc[1] = i_in.data.center_y;
                    n_oc[2] = i_in.data.center_z;
                    n_oe[0] = i_in.data.extent_x;
                    n_oe[1] = i_in.data.extent_y;
                    n_oe[2] = i_in.data.extent_z;
                    n_orad  = i_in.data.radius;
                    case (i_in.data.op)
                        OP_LOAD: begin
                            n_c[0]  = i_in.data.center_x;
                            n_c[1]  = i_in.data.center_y;
                            n_c[2]  = i_in.data.center_z;
                            n_e[0]  = i_in.data.extent_x;
                            n_e[1]  = i_in.data.extent_y;
                            n_e[2]  = i_in.data.extent_z;
                            n_r     = i_in.data.radius;
                            n_state = ST_FIN;
                        end
                        OP_MERGE_PT: begin
                            n_oe[0] = '0;
                            n_oe[1] = '0;
                            n_oe[2] = '0;
                            n_orad  = '0;
                            n_state = ST_BOX;
                        end
                        OP_MERGE_BND: begin
                            n_state = ST_BOX;
                        end
                        default: begin
                            n_state = ST_XC;
                        end
                    endcase
                end
            end
            ST_BOX: begin
                n_c     = w_bc;
                n_e     = w_be;
                n_state = ST_ESQ;
            end
            ST_ESQ: begin
                if (r_cnt == 3'd4) begin
                    w_sq_start = 1'b1;
                    n_state    = ST_ESQRT;
                end
            end
            ST_ESQRT: begin
                if (w_sq_done) begin
                    n_elen  = w_sq_root;
                    n_state = ST_DSQ;
                end
            end
            ST_DSQ: begin
                if (r_cnt == 3'd4) begin
                    w_sq_start = 1'b1;
                    n_state    = ST_DSQRT;
                end
            end
            ST_DSQRT: begin
                // radius = min(extent length, dist + larger radius)
                if (w_sq_done) begin
                    n_r     = (w_rmin[32:31] != 2'b00) ? MAX31 : w_rmin[30:0];
                    n_state = ST_FIN;
                end
            end
            ST_XC: begin
                if (r_cnt == 3'd4) begin
                    if (w_xc[65:31] == '0 || w_xc[65:31] == '1) begin
                        n_tc[r_grp] = w_xc[31:0];
                    end else begin
                        n_tc[r_grp] = w_xc[65] ? MIN_S32 : MAX_S32;
                    end
                    if (r_grp == 2'd2) begin
                        n_grp   = 2'd0;
                        n_state = ST_XE;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end
            end
            ST_XE: begin
                if (r_cnt == 3'd4) begin
                    n_te[r_grp] = (r_acc[63:47] != '0) ? MAX31 : r_acc[46:16];
                    if (r_grp == 2'd2) begin
                        n_grp   = 2'd0;
                        n_state = ST_XS;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end
            end
            ST_XS: begin
                if (r_cnt == 3'd4) begin
                    n_colmax = w_cmax;
                    if (r_grp == 2'd2) begin
                        w_sq_start = 1'b1;
                        n_grp      = 2'd0;
                        n_state    = ST_SSQRT;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end
            end
            ST_SSQRT: begin
                if (w_sq_done) begin
                    n_scale = w_sq_root;
                    n_state = ST_RAD;
                end
            end
            ST_RAD: begin
                // scale radius and commit the transformed bound
                if (r_cnt == 3'd4) begin
                    n_r     = (r_acc[63:47] != '0) ? MAX31 : r_acc[46:16];
                    n_c     = r_tc;
                    n_e     = r_te;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_ovld || o_out.ready) begin
                    n_out.out_center_x = r_c[0];
                    n_out.out_center_y = r_c[1];
                    n_out.out_center_z = r_c[2];
                    n_out.out_extent_x = r_e[0];
                    n_out.out_extent_y = r_e[1];
                    n_out.out_extent_z = r_e[2];
                    n_out.out_radius   = r_r;
                    n_ovld             = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_grp   <= 2'd0;
            r_cnt   <= 3'd0;
            r_ovld  <= 1'b0;
            r_c     <= '{default: '0};
            r_e     <= '{default: '0};
            r_r     <= '0;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
            r_c     <= n_c;
            r_e     <= n_e;
            r_r     <= n_r;
        end
    end

    // Matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'h0000_0001_0000_0000;
            r_mat[1] <= 64'h0;
            r_mat[2] <= 64'h0001_0000_0000_0000;
            r_mat[3] <= 64'h0;
            r_mat[4] <= 64'h0;
            r_mat[5] <= 64'h0000_0000_0001_0000;
        end else if (i_cfg_we && i_cfg_idx < IDX_W'(NUM_REGS)) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_oc     <= n_oc;
        r_oe     <= n_oe;
        r_orad   <= n_orad;
        r_tc     <= n_tc;
        r_te     <= n_te;
        r_prod   <= w_prod;
        r_acc    <= n_acc;
        r_elen   <= n_elen;
        r_colmax <= n_colmax;
        r_scale  <= n_scale;
        r_out    <= n_out;
    end

endmodule
